// ----- rtl/core/tcpq_pkg.sv -----
// Shared types, constants and helper functions for the three-class priority queue.
// Used by tcpq_ctrl, tcpq_dp and three_class_priority_queue; depends on nothing else.
package tcpq_pkg;

  localparam int DEPTH       = 16;
  localparam int ELEM_WIDTH  = 32;
  localparam int NUM_CLASSES = 3;

  localparam int VALUE_W  = 32;
  localparam int TOTAL_W  = 6;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int SLOT_W   = $clog2(DEPTH);
  localparam int ADDR_W   = $clog2(NUM_CLASSES * DEPTH);
  localparam int SUM_W    = CNT_W + 2;
  localparam int TOTAL_MAX = (1 << TOTAL_W) - 1;

  typedef enum logic [1:0] {
    KIND_PUSH   = 2'd0,
    KIND_POP    = 2'd1,
    KIND_CHANGE = 2'd2,
    KIND_SIZE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CLS_LOW  = 2'd0,
    CLS_MED  = 2'd1,
    CLS_HIGH = 2'd2,
    CLS_BAD  = 2'd3
  } cls_e;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_EMPTY    = 3'd1,
    STS_NOMATCH  = 3'd2,
    STS_FULL     = 3'd3,
    STS_BADCLASS = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_POP_WAIT,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FINISH
  } state_e;

  typedef enum logic [1:0] {
    RD_POP_HEAD,
    RD_SEARCH,
    RD_SHIFT_NEXT
  } rd_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    latch;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    push_wr;
    logic    pop_done;
    logic    srch_start;
    logic    srch_next_class;
    logic    idx_inc;
    logic    shift_wr;
    logic    move_done;
    logic    set_status;
    status_e status;
    logic    finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    kind_e kind;
    logic  cls_bad;
    logic  cls_full;
    logic  all_empty;
    logic  srch_has_entry;
    logic  srch_has_next;
    logic  match;
    logic  shift_more;
    logic  out_free;
  } sts_t;

  function automatic logic [ELEM_WIDTH-1:0] to_elem(input logic [VALUE_W-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[ELEM_WIDTH-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] from_elem(input logic [ELEM_WIDTH-1:0] e);
    logic [63:0] w;
    w = 64'(e);
    return w[VALUE_W-1:0];
  endfunction

  // Each class is a ring of DEPTH slots; pos counts from the oldest entry.
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [1:0]        cls,
                                                  input logic [SLOT_W-1:0] head,
                                                  input logic [CNT_W-1:0]  pos);
    logic [CNT_W:0]      sum;
    logic [SLOT_W-1:0]   slot;
    logic [ADDR_W-1:0]   base;
    sum = (CNT_W+1)'(head) + (CNT_W+1)'(pos);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    slot = sum[SLOT_W-1:0];
    case (cls)
      CLS_MED:  base = ADDR_W'(DEPTH);
      CLS_HIGH: base = ADDR_W'(2 * DEPTH);
      default:  base = '0;
    endcase
    return base + ADDR_W'(slot);
  endfunction

endpackage

// ----- rtl/core/tcpq_ctrl.sv -----
// Controller state machine of the three-class priority queue.
// Depends on tcpq_pkg; drives the command struct of tcpq_dp and reads its status.
module tcpq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  tcpq_pkg::sts_t  sts_i,
  output tcpq_pkg::cmd_t  cmd_o
);

  tcpq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcpq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      tcpq_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = tcpq_pkg::S_DECODE;
        end
      end
      tcpq_pkg::S_DECODE: begin
        cmd_o.set_status = 1'b1;
        cmd_o.status     = tcpq_pkg::STS_OK;
        state_d          = tcpq_pkg::S_FINISH;
        case (sts_i.kind)
          tcpq_pkg::KIND_PUSH: begin
            if (sts_i.cls_bad) begin
              cmd_o.status = tcpq_pkg::STS_BADCLASS;
            end else if (sts_i.cls_full) begin
              cmd_o.status = tcpq_pkg::STS_FULL;
            end else begin
              cmd_o.push_wr = 1'b1;
            end
          end
          tcpq_pkg::KIND_POP: begin
            if (sts_i.all_empty) begin
              cmd_o.status = tcpq_pkg::STS_EMPTY;
            end else begin
              cmd_o.set_status = 1'b0;
              cmd_o.rd_en      = 1'b1;
              cmd_o.rd_sel     = tcpq_pkg::RD_POP_HEAD;
              state_d          = tcpq_pkg::S_POP_WAIT;
            end
          end
          tcpq_pkg::KIND_CHANGE: begin
            if (sts_i.cls_bad) begin
              cmd_o.status = tcpq_pkg::STS_BADCLASS;
            end else begin
              cmd_o.set_status = 1'b0;
              cmd_o.srch_start = 1'b1;
              state_d          = tcpq_pkg::S_SRCH_RD;
            end
          end
          default: begin
            // Size query: the count is sampled when the result is loaded.
          end
        endcase
      end
      tcpq_pkg::S_POP_WAIT: begin
        cmd_o.pop_done   = 1'b1;
        cmd_o.set_status = 1'b1;
        cmd_o.status     = tcpq_pkg::STS_OK;
        state_d          = tcpq_pkg::S_FINISH;
      end
      tcpq_pkg::S_SRCH_RD: begin
        if (sts_i.srch_has_entry) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = tcpq_pkg::RD_SEARCH;
          state_d      = tcpq_pkg::S_SRCH_CMP;
        end else if (sts_i.srch_has_next) begin
          cmd_o.srch_next_class = 1'b1;
        end else begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = tcpq_pkg::STS_NOMATCH;
          state_d          = tcpq_pkg::S_FINISH;
        end
      end
      tcpq_pkg::S_SRCH_CMP: begin
        if (sts_i.match) begin
          if (sts_i.cls_full) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = tcpq_pkg::STS_FULL;
            state_d          = tcpq_pkg::S_FINISH;
          end else begin
            state_d = tcpq_pkg::S_SHIFT_RD;
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = tcpq_pkg::S_SRCH_RD;
        end
      end
      tcpq_pkg::S_SHIFT_RD: begin
        if (sts_i.shift_more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = tcpq_pkg::RD_SHIFT_NEXT;
          state_d      = tcpq_pkg::S_SHIFT_WR;
        end else begin
          cmd_o.move_done  = 1'b1;
          cmd_o.set_status = 1'b1;
          cmd_o.status     = tcpq_pkg::STS_OK;
          state_d          = tcpq_pkg::S_FINISH;
        end
      end
      tcpq_pkg::S_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = tcpq_pkg::S_SHIFT_RD;
      end
      tcpq_pkg::S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = tcpq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = tcpq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/tcpq_dp.sv -----
// Datapath of the three-class priority queue: entry memory, class counts and
// ring heads, search position and result registers. Depends on tcpq_pkg.
module tcpq_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tcpq_pkg::cmd_t                 cmd_i,
  output tcpq_pkg::sts_t                 sts_o,
  input  logic [1:0]                     in_kind_i,
  input  logic [1:0]                     in_priority_req_i,
  input  logic [tcpq_pkg::VALUE_W-1:0]   in_value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [2:0]                     out_status_o,
  output logic [tcpq_pkg::VALUE_W-1:0]   out_popped_value_o,
  output logic [tcpq_pkg::TOTAL_W-1:0]   out_total_count_o
);

  logic [tcpq_pkg::ELEM_WIDTH-1:0] mem [tcpq_pkg::NUM_CLASSES * tcpq_pkg::DEPTH];

  logic [tcpq_pkg::CNT_W-1:0]  cnt_q  [tcpq_pkg::NUM_CLASSES];
  logic [tcpq_pkg::SLOT_W-1:0] head_q [tcpq_pkg::NUM_CLASSES];

  tcpq_pkg::kind_e                 kind_q;
  logic [1:0]                      cls_q;
  logic [tcpq_pkg::ELEM_WIDTH-1:0] val_q;
  logic [1:0]                      sc_q;
  logic [tcpq_pkg::CNT_W-1:0]      idx_q;
  logic [tcpq_pkg::ELEM_WIDTH-1:0] rd_data_q;
  tcpq_pkg::status_e               res_status_q;
  logic [tcpq_pkg::VALUE_W-1:0]    res_popped_q;
  logic                            out_valid_q;
  logic [2:0]                      out_status_q;
  logic [tcpq_pkg::VALUE_W-1:0]    out_popped_q;
  logic [tcpq_pkg::TOTAL_W-1:0]    out_total_q;

  logic                            cls_bad;
  logic [tcpq_pkg::CNT_W-1:0]      cnt_cls;
  logic [tcpq_pkg::SLOT_W-1:0]     head_cls;
  logic [1:0]                      pop_cls;
  logic [1:0]                      sc_first;
  logic [1:0]                      sc_next;
  logic                            sc_has_next;
  logic [tcpq_pkg::CNT_W-1:0]      idx_next;
  logic [tcpq_pkg::ADDR_W-1:0]     rd_addr;
  logic                            wr_en;
  logic [tcpq_pkg::ADDR_W-1:0]     wr_addr;
  logic [tcpq_pkg::ELEM_WIDTH-1:0] wr_data;
  logic [tcpq_pkg::SUM_W-1:0]      total_sum;
  logic [tcpq_pkg::TOTAL_W-1:0]    total_sat;
  logic                            out_free;

  assign cls_bad  = (cls_q == tcpq_pkg::CLS_BAD);
  assign idx_next = idx_q + tcpq_pkg::CNT_W'(1);

  // Count and head of the target class; a bad class reads as an empty class.
  always_comb begin
    case (cls_q)
      tcpq_pkg::CLS_LOW: begin
        cnt_cls  = cnt_q[0];
        head_cls = head_q[0];
      end
      tcpq_pkg::CLS_MED: begin
        cnt_cls  = cnt_q[1];
        head_cls = head_q[1];
      end
      tcpq_pkg::CLS_HIGH: begin
        cnt_cls  = cnt_q[2];
        head_cls = head_q[2];
      end
      default: begin
        cnt_cls  = '0;
        head_cls = '0;
      end
    endcase
  end

  always_comb begin
    if (cnt_q[2] != '0) begin
      pop_cls = tcpq_pkg::CLS_HIGH;
    end else if (cnt_q[1] != '0) begin
      pop_cls = tcpq_pkg::CLS_MED;
    end else begin
      pop_cls = tcpq_pkg::CLS_LOW;
    end
  end

  // The search runs high, medium, low and skips the target class.
  assign sc_first = (cls_q == tcpq_pkg::CLS_HIGH) ? tcpq_pkg::CLS_MED : tcpq_pkg::CLS_HIGH;

  always_comb begin
    sc_next     = tcpq_pkg::CLS_LOW;
    sc_has_next = 1'b0;
    case (sc_q)
      tcpq_pkg::CLS_HIGH: begin
        sc_next     = (cls_q == tcpq_pkg::CLS_MED) ? tcpq_pkg::CLS_LOW : tcpq_pkg::CLS_MED;
        sc_has_next = 1'b1;
      end
      tcpq_pkg::CLS_MED: begin
        sc_next     = tcpq_pkg::CLS_LOW;
        sc_has_next = (cls_q != tcpq_pkg::CLS_LOW);
      end
      default: begin
        sc_has_next = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (cmd_i.rd_sel)
      tcpq_pkg::RD_POP_HEAD:
        rd_addr = tcpq_pkg::slot_addr(pop_cls, head_q[pop_cls], '0);
      tcpq_pkg::RD_SHIFT_NEXT:
        rd_addr = tcpq_pkg::slot_addr(sc_q, head_q[sc_q], idx_next);
      default:
        rd_addr = tcpq_pkg::slot_addr(sc_q, head_q[sc_q], idx_q);
    endcase
  end

  // Pushes and moves append at the tail of the target class; shifts close the gap.
  always_comb begin
    wr_en   = cmd_i.push_wr | cmd_i.move_done | cmd_i.shift_wr;
    wr_addr = tcpq_pkg::slot_addr(cls_q, head_cls, cnt_cls);
    wr_data = val_q;
    if (cmd_i.shift_wr) begin
      wr_addr = tcpq_pkg::slot_addr(sc_q, head_q[sc_q], idx_q);
      wr_data = rd_data_q;
    end
  end

  always_comb begin
    total_sum = tcpq_pkg::SUM_W'(cnt_q[0]) + tcpq_pkg::SUM_W'(cnt_q[1])
              + tcpq_pkg::SUM_W'(cnt_q[2]);
    if (total_sum > tcpq_pkg::SUM_W'(tcpq_pkg::TOTAL_MAX)) begin
      total_sat = tcpq_pkg::TOTAL_W'(tcpq_pkg::TOTAL_MAX);
    end else begin
      total_sat = total_sum[tcpq_pkg::TOTAL_W-1:0];
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    sts_o.kind           = kind_q;
    sts_o.cls_bad        = cls_bad;
    sts_o.cls_full       = !cls_bad && (cnt_cls >= tcpq_pkg::CNT_W'(tcpq_pkg::DEPTH));
    sts_o.all_empty      = (cnt_q[0] == '0) && (cnt_q[1] == '0) && (cnt_q[2] == '0);
    sts_o.srch_has_entry = (idx_q < cnt_q[sc_q]);
    sts_o.srch_has_next  = sc_has_next;
    sts_o.match          = (rd_data_q == val_q);
    sts_o.shift_more     = (idx_next < cnt_q[sc_q]);
    sts_o.out_free       = out_free;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '{default: '0};
      head_q      <= '{default: '0};
      out_valid_q <= 1'b0;
    end else begin
      for (int c = 0; c < tcpq_pkg::NUM_CLASSES; c++) begin
        if (cmd_i.pop_done && (pop_cls == 2'(c))) begin
          cnt_q[c] <= cnt_q[c] - tcpq_pkg::CNT_W'(1);
          if (head_q[c] == tcpq_pkg::SLOT_W'(tcpq_pkg::DEPTH - 1)) begin
            head_q[c] <= '0;
          end else begin
            head_q[c] <= head_q[c] + tcpq_pkg::SLOT_W'(1);
          end
        end
        if ((cmd_i.push_wr || cmd_i.move_done) && (cls_q == 2'(c))) begin
          cnt_q[c] <= cnt_q[c] + tcpq_pkg::CNT_W'(1);
        end
        if (cmd_i.move_done && (sc_q == 2'(c))) begin
          cnt_q[c] <= cnt_q[c] - tcpq_pkg::CNT_W'(1);
        end
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q       <= tcpq_pkg::kind_e'(in_kind_i);
      cls_q        <= in_priority_req_i;
      val_q        <= tcpq_pkg::to_elem(in_value_i);
      res_popped_q <= '0;
    end
    if (cmd_i.srch_start) begin
      sc_q  <= sc_first;
      idx_q <= '0;
    end else if (cmd_i.srch_next_class) begin
      sc_q  <= sc_next;
      idx_q <= '0;
    end else if (cmd_i.idx_inc || cmd_i.shift_wr) begin
      idx_q <= idx_next;
    end
    if (cmd_i.pop_done) begin
      res_popped_q <= tcpq_pkg::from_elem(rd_data_q);
    end
    if (cmd_i.set_status) begin
      res_status_q <= cmd_i.status;
    end
    if (cmd_i.finish) begin
      out_status_q <= res_status_q;
      out_popped_q <= res_popped_q;
      out_total_q  <= total_sat;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_status_o       = out_status_q;
  assign out_popped_value_o = out_popped_q;
  assign out_total_count_o  = out_total_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[0] <= tcpq_pkg::CNT_W'(tcpq_pkg::DEPTH)) &&
    (cnt_q[1] <= tcpq_pkg::CNT_W'(tcpq_pkg::DEPTH)) &&
    (cnt_q[2] <= tcpq_pkg::CNT_W'(tcpq_pkg::DEPTH)))
    else $error("class count above depth");

  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.push_wr, cmd_i.move_done, cmd_i.shift_wr, cmd_i.pop_done}))
    else $error("more than one queue update in one cycle");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !cmd_i.finish)
    else $error("result overwritten while the output beat is stalled");

  a_move_other_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.move_done |-> (sc_q != cls_q) && (cnt_q[sc_q] != '0))
    else $error("move from target class or from an empty class");

endmodule

// ----- rtl/core/three_class_priority_queue.sv -----
// Top level of the three-class strict-priority queue; instantiates tcpq_ctrl and
// tcpq_dp and depends on tcpq_pkg.
//
// The block holds three FIFO classes (low, medium, high) of DEPTH entries each in a
// two-port entry memory, every class kept as a ring with its own head and count.
// Work is done one request at a time; a request is taken only while the controller is
// idle, and the result sits in an output register so the next request may be taken
// while that beat is still stalled. A push or size query goes from the accept to decode
// and finish; a pop adds a wait state for the registered memory read. A class change
// reads and compares each entry examined in the search, moves on to the next class once
// one is searched through, reads and writes back every younger entry of the source class
// that slides down to close the gap, and then appends the moved entry and finishes.
// A finished request also waits, before the controller goes idle again, for as long as
// the previous result beat stays stalled. The memory gives one registered read and one
// write per cycle. After reset all classes are empty and requests are taken at once.
module three_class_priority_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   in_kind_i,
  input  logic [1:0]                   in_priority_req_i,
  input  logic [tcpq_pkg::VALUE_W-1:0] in_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   out_status_o,
  output logic [tcpq_pkg::VALUE_W-1:0] out_popped_value_o,
  output logic [tcpq_pkg::TOTAL_W-1:0] out_total_count_o
);

  tcpq_pkg::cmd_t cmd;
  tcpq_pkg::sts_t sts;

  tcpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcpq_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .in_kind_i          (in_kind_i),
    .in_priority_req_i  (in_priority_req_i),
    .in_value_i         (in_value_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_status_o       (out_status_o),
    .out_popped_value_o (out_popped_value_o),
    .out_total_count_o  (out_total_count_o)
  );

endmodule
